// File: rtl/core/clc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clc_pkg
// Shared types and constants of the configuration line cleaner.
// ----------------------------------------------------------------------------
package clc_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] ChHash      = 8'h23;
  localparam logic [7:0] ChNewline   = 8'h0a;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChSquote    = 8'h27;

  typedef enum logic [2:0] {
    MODE_START   = 3'd0,
    MODE_HEADCMT = 3'd1,
    MODE_LINE    = 3'd2,
    MODE_MIDCMT  = 3'd3,
    MODE_ESCAPE  = 3'd4,
    MODE_NEWLINE = 3'd5
  } scan_mode_e;

  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_DOUBLE = 2'd1,
    Q_SINGLE = 2'd2
  } quote_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       line_end;
    logic       last;
  } out_word_t;

  typedef struct packed {
    scan_mode_e scan_mode;
    quote_e     open_quote;
    logic       line_nonempty;
    logic       comment_prev_backslash;
  } clc_state_t;

  typedef struct packed {
    logic [1:0] cnt;
    out_word_t  w0;
    out_word_t  w1;
  } clc_res_t;

endpackage
`default_nettype wire

// File: rtl/core/clc_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clc_step
// Next state and up to two result words for one input byte.
// ----------------------------------------------------------------------------
module clc_step (
  input  wire logic               sq_en_i,
  input  wire clc_pkg::clc_state_t state_i,
  input  wire clc_pkg::in_word_t   word_i,
  output clc_pkg::clc_state_t      state_o,
  output clc_pkg::clc_res_t        res_o
);

  typedef struct packed {
    clc_pkg::clc_state_t st;
    clc_pkg::clc_res_t   res;
  } step_t;

  function automatic step_t put(step_t x, logic [7:0] ch, logic e);
    step_t y;
    y = x;
    if (y.res.cnt == 2'd0) begin
      y.res.w0 = '{out_char: ch, line_end: e, last: 1'b0};
      y.res.cnt = 2'd1;
    end else if (y.res.cnt == 2'd1) begin
      y.res.w1 = '{out_char: ch, line_end: e, last: 1'b0};
      y.res.cnt = 2'd2;
    end
    if (!e) begin
      y.st.line_nonempty = 1'b1;
    end
    return y;
  endfunction

  function automatic step_t finish_line(step_t x);
    step_t y;
    y = x;
    if (y.st.line_nonempty) begin
      y = put(y, 8'h00, 1'b1);
    end
    y.st.line_nonempty = 1'b0;
    y.st.open_quote = clc_pkg::Q_NONE;
    y.st.comment_prev_backslash = 1'b0;
    return y;
  endfunction

  function automatic step_t in_line(step_t x, logic [7:0] c, logic sq);
    step_t y;
    logic  close_hit;
    y = x;
    close_hit = (y.st.open_quote == clc_pkg::Q_DOUBLE && c == clc_pkg::ChDquote) ||
                (y.st.open_quote == clc_pkg::Q_SINGLE && c == clc_pkg::ChSquote);
    if (close_hit) begin
      y.st.open_quote = clc_pkg::Q_NONE;
      y = put(y, c, 1'b0);
    end else if (c == clc_pkg::ChHash && y.st.open_quote == clc_pkg::Q_NONE) begin
      y.st.scan_mode = clc_pkg::MODE_MIDCMT;
      y.st.comment_prev_backslash = 1'b0;
    end else if (c == clc_pkg::ChNewline && y.st.open_quote == clc_pkg::Q_NONE) begin
      y.st.scan_mode = clc_pkg::MODE_NEWLINE;
    end else if (c == clc_pkg::ChBackslash) begin
      y.st.scan_mode = clc_pkg::MODE_ESCAPE;
    end else begin
      if (y.st.open_quote == clc_pkg::Q_NONE) begin
        if (c == clc_pkg::ChDquote) begin
          y.st.open_quote = clc_pkg::Q_DOUBLE;
        end else if (c == clc_pkg::ChSquote && sq) begin
          y.st.open_quote = clc_pkg::Q_SINGLE;
        end
      end
      y = put(y, c, 1'b0);
    end
    return y;
  endfunction

  function automatic step_t line_start(step_t x, logic [7:0] c, logic sq);
    step_t y;
    y = x;
    if (c == clc_pkg::ChSpace || c == clc_pkg::ChTab || c == clc_pkg::ChNewline) begin
      y.st.scan_mode = clc_pkg::MODE_START;
    end else if (c == clc_pkg::ChHash) begin
      y.st.scan_mode = clc_pkg::MODE_HEADCMT;
    end else begin
      y.st.scan_mode = clc_pkg::MODE_LINE;
      y = in_line(y, c, sq);
    end
    return y;
  endfunction

  always_comb begin
    step_t      x;
    logic [7:0] c;
    c = word_i.in_byte;
    x.st = state_i;
    x.res = '0;
    if (word_i.end_of_text) begin
      if (x.st.scan_mode == clc_pkg::MODE_ESCAPE) begin
        x = put(x, clc_pkg::ChBackslash, 1'b0);
      end
      if (x.st.scan_mode == clc_pkg::MODE_LINE || x.st.scan_mode == clc_pkg::MODE_MIDCMT ||
          x.st.scan_mode == clc_pkg::MODE_ESCAPE || x.st.scan_mode == clc_pkg::MODE_NEWLINE) begin
        x = finish_line(x);
      end
      x.st.scan_mode = clc_pkg::MODE_START;
      x.st.open_quote = clc_pkg::Q_NONE;
      x.st.line_nonempty = 1'b0;
      x.st.comment_prev_backslash = 1'b0;
    end else begin
      unique case (x.st.scan_mode)
        clc_pkg::MODE_HEADCMT: begin
          if (c == clc_pkg::ChNewline) begin
            x.st.scan_mode = clc_pkg::MODE_START;
          end
        end
        clc_pkg::MODE_LINE: begin
          x = in_line(x, c, sq_en_i);
        end
        clc_pkg::MODE_MIDCMT: begin
          if (c == clc_pkg::ChNewline) begin
            if (x.st.comment_prev_backslash) begin
              x.st.comment_prev_backslash = 1'b0;
              x.st.scan_mode = clc_pkg::MODE_LINE;
            end else begin
              x = finish_line(x);
              x.st.scan_mode = clc_pkg::MODE_START;
            end
          end else begin
            x.st.comment_prev_backslash = (c == clc_pkg::ChBackslash);
          end
        end
        clc_pkg::MODE_ESCAPE: begin
          x.st.scan_mode = clc_pkg::MODE_LINE;
          if (c == clc_pkg::ChNewline) begin
            x.st.scan_mode = clc_pkg::MODE_LINE;
          end else if (c == clc_pkg::ChHash && x.st.open_quote == clc_pkg::Q_NONE) begin
            x = put(x, clc_pkg::ChHash, 1'b0);
          end else begin
            x = put(x, clc_pkg::ChBackslash, 1'b0);
            x = put(x, c, 1'b0);
          end
        end
        clc_pkg::MODE_NEWLINE: begin
          if (c == clc_pkg::ChSpace || c == clc_pkg::ChTab) begin
            x.st.scan_mode = clc_pkg::MODE_LINE;
            x = put(x, c, 1'b0);
          end else begin
            x = finish_line(x);
            x = line_start(x, c, sq_en_i);
          end
        end
        default: begin
          x = line_start(x, c, sq_en_i);
        end
      endcase
    end
    if (x.res.cnt == 2'd1) begin
      x.res.w0.last = 1'b1;
    end else if (x.res.cnt == 2'd2) begin
      x.res.w1.last = 1'b1;
    end
    state_o = x.st;
    res_o = x.res;
  end

endmodule
`default_nettype wire

// File: rtl/core/clc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clc_queue
// Result queue: takes up to two words a cycle, hands out one.
// ----------------------------------------------------------------------------
module clc_queue #(
  parameter int unsigned Depth = clc_pkg::QueueDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire clc_pkg::clc_res_t push_i,
  input  wire logic              pop_i,
  output logic                   room_o,
  output logic                   valid_o,
  output clc_pkg::out_word_t     word_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  clc_pkg::out_word_t mem_q [Depth];
  logic [PtrW-1:0]    wr_q, wr_d, rd_q, rd_d, wr_nx;
  logic [CntW-1:0]    cnt_q, cnt_d;

  always_comb begin
    wr_nx = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    wr_d = wr_q;
    if (push_i.cnt == 2'd1) begin
      wr_d = wr_nx;
    end else if (push_i.cnt == 2'd2) begin
      wr_d = (wr_nx == PtrW'(Depth - 1)) ? '0 : wr_nx + 1'b1;
    end
    rd_d = rd_q;
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(push_i.cnt) - CntW'(pop_i);
  end

  assign room_o  = cnt_q <= CntW'(Depth - 2);
  assign valid_o = cnt_q != '0;
  assign word_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.w0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_nx] <= push_i.w1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/config_line_cleaner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// config_line_cleaner
// Cleans a configuration text byte stream into logical line characters.
// ----------------------------------------------------------------------------
// One text byte per input word; each byte yields zero, one or two result
// words, a line-end word closing every nonempty line. A byte is taken into
// an input register and processed once the result queue has room; its
// results are then written into a result queue of QueueDepth words (four by
// default), from which the output port offers them. Input is accepted every
// cycle while the queue has room for two words; the sustained rate is set
// by the single result port at one result word per cycle while the output
// is not stalled. The quote option register is written over its own port,
// which is always ready.
// ----------------------------------------------------------------------------
module config_line_cleaner #(
  parameter int unsigned QueueDepth = clc_pkg::QueueDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic              cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire clc_pkg::in_word_t in_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output clc_pkg::out_word_t     out_o
);

  logic                sq_en_q;
  logic                in_valid_q;
  clc_pkg::in_word_t   in_q;
  clc_pkg::clc_state_t state_q, state_d;
  clc_pkg::clc_res_t   res, push;
  logic                room, proc;

  assign cfg_ready_o = 1'b1;
  assign proc        = in_valid_q & room;
  assign in_stall_o  = in_valid_q & ~room;

  clc_step u_step (
    .sq_en_i (sq_en_q),
    .state_i (state_q),
    .word_i  (in_q),
    .state_o (state_d),
    .res_o   (res)
  );

  always_comb begin
    push = res;
    if (!proc) begin
      push.cnt = 2'd0;
    end
  end

  clc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_valid_o & ~out_stall_i),
    .room_o  (room),
    .valid_o (out_valid_o),
    .word_o  (out_o)
  );

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_en_q    <= 1'b0;
      in_valid_q <= 1'b0;
      state_q    <= '{scan_mode: clc_pkg::MODE_START, open_quote: clc_pkg::Q_NONE,
                      line_nonempty: 1'b0, comment_prev_backslash: 1'b0};
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        sq_en_q <= cfg_data_i;
      end
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (proc) begin
        state_q <= state_d;
      end
    end
  end

endmodule
`default_nettype wire
